// ===== sv/iw53_pkg.sv =====
`default_nettype none
package iw53_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int COEF_BITS_DEF  = 20;

  localparam int DIM_W   = 9;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 20;
  localparam int CMD_W   = 2;
  localparam int TAP_W   = 4;
  localparam int PASS_W  = 2;

  localparam logic [DIM_W-1:0] IMG_DIM_RST = 9'd256;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

  localparam logic CFG_IMG_WIDTH  = 1'b0;
  localparam logic CFG_IMG_HEIGHT = 1'b1;

  // lifting passes in the order they run
  localparam logic [PASS_W-1:0] PASS_LL = 2'd0;
  localparam logic [PASS_W-1:0] PASS_AD = 2'd1;
  localparam logic [PASS_W-1:0] PASS_D2 = 2'd2;
  localparam logic [PASS_W-1:0] PASS_D1 = 2'd3;

  localparam logic [TAP_W-1:0] TAP_CENTRE = 4'd0;
  localparam logic [TAP_W-1:0] TAP_N      = 4'd1;
  localparam logic [TAP_W-1:0] TAP_S      = 4'd2;
  localparam logic [TAP_W-1:0] TAP_W_     = 4'd3;
  localparam logic [TAP_W-1:0] TAP_E      = 4'd4;
  localparam logic [TAP_W-1:0] TAP_NW     = 4'd5;
  localparam logic [TAP_W-1:0] TAP_NE     = 4'd6;
  localparam logic [TAP_W-1:0] TAP_SW     = 4'd7;
  localparam logic [TAP_W-1:0] TAP_SE     = 4'd8;

  typedef struct packed {
    logic              clr;
    logic              acc_en;
    logic [TAP_W-1:0]  tap;
    logic [PASS_W-1:0] pass;
  } lift_ctl_t;

endpackage
`default_nettype wire

// ===== sv/iw53_ram.sv =====
`default_nettype none
module iw53_ram #(
  parameter int WIDTH = iw53_pkg::COEF_BITS_DEF,
  parameter int DEPTH = iw53_pkg::MAX_WIDTH_DEF * iw53_pkg::MAX_HEIGHT_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire                     re_i,
  input  wire  [AW-1:0]           addr_i,
  input  wire  [WIDTH-1:0]        wdata_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/iw53_lift.sv =====
`default_nettype none
module iw53_lift #(
  parameter int COEF_BITS = iw53_pkg::COEF_BITS_DEF
) (
  input  wire                          clk_i,
  input  iw53_pkg::lift_ctl_t          ctl_i,
  input  wire  signed [COEF_BITS-1:0]  rdata_i,
  output logic signed [COEF_BITS-1:0]  new_o
);

  localparam int ACC_W = COEF_BITS + 6;

  logic signed [ACC_W-1:0]     acc_q;
  logic signed [COEF_BITS-1:0] centre_q;
  logic signed [ACC_W-1:0]     v;
  logic signed [ACC_W-1:0]     term;
  logic signed [ACC_W-1:0]     sum;
  logic signed [ACC_W-1:0]     t;
  logic signed [ACC_W-1:0]     res;
  logic                        is_cross;

  always_comb begin
    v        = ACC_W'(rdata_i);
    is_cross = ctl_i.tap inside {[iw53_pkg::TAP_N:iw53_pkg::TAP_E]};
    term     = '0;
    case (ctl_i.pass)
      iw53_pkg::PASS_LL: term = is_cross ? (v <<< 2) : -v;
      iw53_pkg::PASS_AD: term = (ctl_i.tap inside {iw53_pkg::TAP_N, iw53_pkg::TAP_S}) ?
                                v : -(v <<< 1);
      iw53_pkg::PASS_D2: term = (ctl_i.tap inside {iw53_pkg::TAP_N, iw53_pkg::TAP_S}) ?
                                -(v <<< 1) : v;
      iw53_pkg::PASS_D1: term = is_cross ? (v <<< 1) : -v;
      default:           term = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      if (ctl_i.tap == iw53_pkg::TAP_CENTRE) begin
        centre_q <= rdata_i;
      end else begin
        acc_q <= acc_q + term;
      end
    end
  end

  // arithmetic shift gives floor rounding
  always_comb begin
    if (ctl_i.pass == iw53_pkg::PASS_LL) begin
      sum = acc_q + ACC_W'(8);
      t   = sum >>> 4;
    end else begin
      sum = acc_q + ACC_W'(2);
      t   = sum >>> 2;
    end
    if (ctl_i.pass == iw53_pkg::PASS_D1) begin
      res = ACC_W'(centre_q) + t;
    end else begin
      res = ACC_W'(centre_q) - t;
    end
    new_o = res[COEF_BITS-1:0];
  end

endmodule
`default_nettype wire

// ===== sv/iw53_ctrl.sv =====
`default_nettype none
module iw53_ctrl #(
  parameter int MAX_WIDTH  = iw53_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iw53_pkg::MAX_HEIGHT_DEF,
  parameter int COEF_BITS  = iw53_pkg::COEF_BITS_DEF,
  localparam int IMG_AW  = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int WK_AW   = $clog2((MAX_WIDTH + 2) * (MAX_HEIGHT + 2)),
  localparam int WSTRIDE = MAX_WIDTH + 2
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  input  wire  [iw53_pkg::CMD_W-1:0]            command_i,
  input  wire  [iw53_pkg::POS_W-1:0]            column_i,
  input  wire  [iw53_pkg::POS_W-1:0]            row_i,
  input  wire  signed [iw53_pkg::VALUE_W-1:0]   write_value_i,
  input  wire  [iw53_pkg::DIM_W-1:0]            region_width_i,
  input  wire  [iw53_pkg::DIM_W-1:0]            region_height_i,
  input  wire                                   cfg_we_i,
  input  wire                                   cfg_index_i,
  input  wire  [iw53_pkg::DIM_W-1:0]            cfg_data_i,
  output logic                                  busy_o,
  output logic                                  done_o,
  output logic                                  status_o,
  output logic                                  rd_pend_o,
  output logic                                  img_we_o,
  output logic                                  img_re_o,
  output logic [IMG_AW-1:0]                     img_addr_o,
  output logic signed [COEF_BITS-1:0]           img_wdata_o,
  input  wire  signed [COEF_BITS-1:0]           img_rdata_i,
  output logic                                  wk_we_o,
  output logic                                  wk_re_o,
  output logic [WK_AW-1:0]                      wk_addr_o,
  output logic signed [COEF_BITS-1:0]           wk_wdata_o,
  input  wire  signed [COEF_BITS-1:0]           wk_rdata_i,
  output iw53_pkg::lift_ctl_t                   lift_o,
  input  wire  signed [COEF_BITS-1:0]           lift_new_i
);

  localparam int DW = iw53_pkg::DIM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_G_RD, S_G_WR, S_EA_RD, S_EA_WR, S_EB_RD, S_EB_WR,
    S_L_RD, S_L_LAST, S_L_WR, S_W_RD, S_W_WR
  } state_e;

  state_e                       state_q;
  logic [DW-1:0]                img_w_q, img_h_q, w_q, h_q, r_q, c_q;
  logic                         sel_q;
  logic [iw53_pkg::PASS_W-1:0]  pass_q;
  logic [iw53_pkg::TAP_W-1:0]   tap_q;
  logic                         done_q, status_q, rd_pend_q;

  logic                         img_ok, pos_ok, run_ok, done_d, rd_pend_d;
  logic [DW-1:0]                hw, hh, sr, sc, img_row, img_col, wk_r, wk_c, r0, c0;
  logic [iw53_pkg::TAP_W-1:0]   tap_last;

  assign img_ok = (int'(img_w_q) <= MAX_WIDTH) && (int'(img_h_q) <= MAX_HEIGHT);
  assign pos_ok = img_ok && ({1'b0, column_i} < img_w_q) && ({1'b0, row_i} < img_h_q);
  assign run_ok = img_ok && (region_width_i >= DW'(2)) && (region_height_i >= DW'(2)) &&
                  (region_width_i <= img_w_q) && (region_height_i <= img_h_q);

  // result beat for every accepted command except a run that starts, and at the run's end
  assign done_d    = (state_q == S_IDLE && start_i &&
                      !(command_i == iw53_pkg::CMD_RUN && run_ok)) ||
                     (state_q == S_W_WR && c_q == w_q && r_q == h_q);
  assign rd_pend_d = state_q == S_IDLE && start_i && command_i == iw53_pkg::CMD_READ && pos_ok;

  assign hw = w_q >> 1;
  assign hh = h_q >> 1;
  // subband source of work position: low band lands on even rows and columns
  assign sr = r_q[0] ? hh + (r_q >> 1) : (r_q >> 1) - DW'(1);
  assign sc = c_q[0] ? hw + (c_q >> 1) : (c_q >> 1) - DW'(1);

  assign r0 = (pass_q == iw53_pkg::PASS_LL || pass_q == iw53_pkg::PASS_AD) ? DW'(2) : DW'(1);
  assign c0 = (pass_q == iw53_pkg::PASS_LL || pass_q == iw53_pkg::PASS_D2) ? DW'(2) : DW'(1);
  assign tap_last = (pass_q == iw53_pkg::PASS_AD || pass_q == iw53_pkg::PASS_D2) ?
                    iw53_pkg::TAP_E : iw53_pkg::TAP_SE;

  always_comb begin
    case (state_q)
      S_G_RD:  begin img_row = sr;              img_col = sc;              end
      S_W_WR:  begin img_row = r_q - DW'(1);    img_col = c_q - DW'(1);    end
      default: begin img_row = DW'(row_i);      img_col = DW'(column_i);   end
    endcase
    img_addr_o  = IMG_AW'(img_row) * IMG_AW'(img_w_q) + IMG_AW'(img_col);
    img_re_o    = (state_q == S_IDLE && start_i && command_i == iw53_pkg::CMD_READ && pos_ok)
                  || state_q == S_G_RD;
    img_we_o    = (state_q == S_IDLE && start_i && command_i == iw53_pkg::CMD_WRITE && pos_ok)
                  || state_q == S_W_WR;
    img_wdata_o = (state_q == S_IDLE) ? COEF_BITS'(write_value_i) : wk_rdata_i;
  end

  always_comb begin
    wk_r = r_q;
    wk_c = c_q;
    case (state_q)
      S_EA_RD: wk_r = sel_q ? h_q - DW'(1) : DW'(2);
      S_EA_WR: wk_r = sel_q ? h_q + DW'(1) : DW'(0);
      S_EB_RD: wk_c = sel_q ? w_q - DW'(1) : DW'(2);
      S_EB_WR: wk_c = sel_q ? w_q + DW'(1) : DW'(0);
      S_L_RD: begin
        case (tap_q)
          iw53_pkg::TAP_N:  wk_r = r_q - DW'(1);
          iw53_pkg::TAP_S:  wk_r = r_q + DW'(1);
          iw53_pkg::TAP_W_: wk_c = c_q - DW'(1);
          iw53_pkg::TAP_E:  wk_c = c_q + DW'(1);
          iw53_pkg::TAP_NW: begin wk_r = r_q - DW'(1); wk_c = c_q - DW'(1); end
          iw53_pkg::TAP_NE: begin wk_r = r_q - DW'(1); wk_c = c_q + DW'(1); end
          iw53_pkg::TAP_SW: begin wk_r = r_q + DW'(1); wk_c = c_q - DW'(1); end
          iw53_pkg::TAP_SE: begin wk_r = r_q + DW'(1); wk_c = c_q + DW'(1); end
          default: ;
        endcase
      end
      default: ;
    endcase
    wk_addr_o = WK_AW'(wk_r) * WK_AW'(WSTRIDE) + WK_AW'(wk_c);
    wk_re_o   = state_q inside {S_EA_RD, S_EB_RD, S_L_RD, S_W_RD};
    wk_we_o   = state_q inside {S_G_WR, S_EA_WR, S_EB_WR, S_L_WR};
    case (state_q)
      S_G_WR:  wk_wdata_o = img_rdata_i;
      S_L_WR:  wk_wdata_o = lift_new_i;
      default: wk_wdata_o = wk_rdata_i;
    endcase
  end

  always_comb begin
    lift_o.clr    = (state_q == S_L_RD) && (tap_q == iw53_pkg::TAP_CENTRE);
    lift_o.acc_en = ((state_q == S_L_RD) && (tap_q != iw53_pkg::TAP_CENTRE)) ||
                    (state_q == S_L_LAST);
    lift_o.tap    = (state_q == S_L_LAST) ? tap_last : tap_q - iw53_pkg::TAP_W'(1);
    lift_o.pass   = pass_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      img_w_q   <= iw53_pkg::IMG_DIM_RST;
      img_h_q   <= iw53_pkg::IMG_DIM_RST;
      w_q       <= '0;
      h_q       <= '0;
      r_q       <= '0;
      c_q       <= '0;
      sel_q     <= 1'b0;
      pass_q    <= iw53_pkg::PASS_LL;
      tap_q     <= iw53_pkg::TAP_CENTRE;
      done_q    <= 1'b0;
      status_q  <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      done_q    <= done_d;
      rd_pend_q <= rd_pend_d;
      if (cfg_we_i) begin
        if (cfg_index_i == iw53_pkg::CFG_IMG_WIDTH) begin
          img_w_q <= cfg_data_i;
        end else begin
          img_h_q <= cfg_data_i;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            case (command_i)
              iw53_pkg::CMD_WRITE: status_q <= !pos_ok;
              iw53_pkg::CMD_READ:  status_q <= !pos_ok;
              iw53_pkg::CMD_RUN: begin
                if (run_ok) begin
                  w_q     <= region_width_i;
                  h_q     <= region_height_i;
                  r_q     <= DW'(1);
                  c_q     <= DW'(1);
                  state_q <= S_G_RD;
                end else begin
                  status_q <= 1'b1;
                end
              end
              default: status_q <= 1'b1;
            endcase
          end
        end
        S_G_RD: state_q <= S_G_WR;
        S_G_WR: begin
          if (c_q == w_q) begin
            c_q <= DW'(1);
            if (r_q == h_q) begin
              pass_q  <= iw53_pkg::PASS_LL;
              sel_q   <= 1'b0;
              state_q <= S_EA_RD;
            end else begin
              r_q     <= r_q + DW'(1);
              state_q <= S_G_RD;
            end
          end else begin
            c_q     <= c_q + DW'(1);
            state_q <= S_G_RD;
          end
        end
        S_EA_RD: state_q <= S_EA_WR;
        S_EA_WR: begin
          sel_q <= !sel_q;
          if (sel_q && c_q == w_q) begin
            r_q     <= '0;
            state_q <= S_EB_RD;
          end else begin
            state_q <= S_EA_RD;
            if (sel_q) begin
              c_q <= c_q + DW'(1);
            end
          end
        end
        S_EB_RD: state_q <= S_EB_WR;
        S_EB_WR: begin
          sel_q <= !sel_q;
          if (sel_q && r_q == h_q + DW'(1)) begin
            r_q     <= r0;
            c_q     <= c0;
            tap_q   <= iw53_pkg::TAP_CENTRE;
            state_q <= S_L_RD;
          end else begin
            state_q <= S_EB_RD;
            if (sel_q) begin
              r_q <= r_q + DW'(1);
            end
          end
        end
        S_L_RD: begin
          tap_q <= tap_q + iw53_pkg::TAP_W'(1);
          if (tap_q == tap_last) begin
            state_q <= S_L_LAST;
          end
        end
        S_L_LAST: state_q <= S_L_WR;
        S_L_WR: begin
          tap_q <= iw53_pkg::TAP_CENTRE;
          if (c_q + DW'(2) <= w_q) begin
            c_q     <= c_q + DW'(2);
            state_q <= S_L_RD;
          end else if (r_q + DW'(2) <= h_q) begin
            c_q     <= c0;
            r_q     <= r_q + DW'(2);
            state_q <= S_L_RD;
          end else begin
            c_q <= DW'(1);
            if (pass_q == iw53_pkg::PASS_D1) begin
              r_q     <= DW'(1);
              state_q <= S_W_RD;
            end else begin
              pass_q  <= pass_q + iw53_pkg::PASS_W'(1);
              sel_q   <= 1'b0;
              state_q <= S_EA_RD;
            end
          end
        end
        S_W_RD: state_q <= S_W_WR;
        S_W_WR: begin
          if (c_q == w_q) begin
            c_q <= DW'(1);
            if (r_q == h_q) begin
              status_q <= 1'b0;
              state_q  <= S_IDLE;
            end else begin
              r_q     <= r_q + DW'(1);
              state_q <= S_W_RD;
            end
          end else begin
            c_q     <= c_q + DW'(1);
            state_q <= S_W_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign rd_pend_o = rd_pend_q;

endmodule
`default_nettype wire

// ===== sv/inverse_2d_nonseparable_53_wavelet.sv =====
// channel   signals                                            direction
// command   start_i busy_o command_i column_i row_i             in
//           write_value_i region_width_i region_height_i
// result    done_o read_value_o status_o                       out
// config    cfg_we_i cfg_index_i cfg_data_i                    in
//
// write and read leave busy_o low; the result beat comes in the cycle after start
// run accepts no new command until it ends
// busy_o is high for the whole run; the result beat comes as busy_o drops
// reset clears control only; both memories hold garbage until written
// done_o is a one-cycle strobe and cannot be stalled
`default_nettype none
module inverse_2d_nonseparable_53_wavelet #(
  parameter int MAX_WIDTH  = iw53_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iw53_pkg::MAX_HEIGHT_DEF,
  parameter int COEF_BITS  = iw53_pkg::COEF_BITS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  output logic                                  busy_o,
  input  wire  [iw53_pkg::CMD_W-1:0]            command_i,
  input  wire  [iw53_pkg::POS_W-1:0]            column_i,
  input  wire  [iw53_pkg::POS_W-1:0]            row_i,
  input  wire  signed [iw53_pkg::VALUE_W-1:0]   write_value_i,
  input  wire  [iw53_pkg::DIM_W-1:0]            region_width_i,
  input  wire  [iw53_pkg::DIM_W-1:0]            region_height_i,
  input  wire                                   cfg_we_i,
  input  wire                                   cfg_index_i,
  input  wire  [iw53_pkg::DIM_W-1:0]            cfg_data_i,
  output logic                                  done_o,
  output logic signed [iw53_pkg::VALUE_W-1:0]   read_value_o,
  output logic                                  status_o
);

  localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int WK_DEPTH  = (MAX_WIDTH + 2) * (MAX_HEIGHT + 2);
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int WK_AW     = $clog2(WK_DEPTH);

  logic                        rd_pend;
  logic                        img_we, img_re, wk_we, wk_re;
  logic [IMG_AW-1:0]           img_addr;
  logic [WK_AW-1:0]            wk_addr;
  logic signed [COEF_BITS-1:0] img_wdata, img_rdata, wk_wdata, wk_rdata, lift_new;
  iw53_pkg::lift_ctl_t         lift_ctl;

  iw53_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COEF_BITS (COEF_BITS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i,
    .command_i,
    .column_i,
    .row_i,
    .write_value_i,
    .region_width_i,
    .region_height_i,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .busy_o,
    .done_o,
    .status_o,
    .rd_pend_o  (rd_pend),
    .img_we_o   (img_we),
    .img_re_o   (img_re),
    .img_addr_o (img_addr),
    .img_wdata_o(img_wdata),
    .img_rdata_i(img_rdata),
    .wk_we_o    (wk_we),
    .wk_re_o    (wk_re),
    .wk_addr_o  (wk_addr),
    .wk_wdata_o (wk_wdata),
    .wk_rdata_i (wk_rdata),
    .lift_o     (lift_ctl),
    .lift_new_i (lift_new)
  );

  iw53_ram #(.WIDTH(COEF_BITS), .DEPTH(IMG_DEPTH)) u_img_ram (
    .clk_i,
    .we_i   (img_we),
    .re_i   (img_re),
    .addr_i (img_addr),
    .wdata_i(img_wdata),
    .rdata_o(img_rdata)
  );

  iw53_ram #(.WIDTH(COEF_BITS), .DEPTH(WK_DEPTH)) u_wk_ram (
    .clk_i,
    .we_i   (wk_we),
    .re_i   (wk_re),
    .addr_i (wk_addr),
    .wdata_i(wk_wdata),
    .rdata_o(wk_rdata)
  );

  iw53_lift #(.COEF_BITS(COEF_BITS)) u_lift (
    .clk_i,
    .ctl_i  (lift_ctl),
    .rdata_i(wk_rdata),
    .new_o  (lift_new)
  );

  assign read_value_o = rd_pend ? iw53_pkg::VALUE_W'(img_rdata) : '0;

endmodule
`default_nettype wire

// ===== sv/iw53_chk.sv =====
`default_nettype none
module iw53_chk (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 start_i,
  input wire                                 busy_o,
  input wire [iw53_pkg::CMD_W-1:0]           command_i,
  input wire                                 done_o,
  input wire [iw53_pkg::VALUE_W-1:0]         read_value_o,
  input wire                                 status_o
);

  logic acc_rw, acc_run;
  assign acc_rw  = start_i && !busy_o &&
                   (command_i == iw53_pkg::CMD_WRITE || command_i == iw53_pkg::CMD_READ);
  assign acc_run = start_i && !busy_o && command_i == iw53_pkg::CMD_RUN;

  a_rw_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_rw |=> done_o && !busy_o)
    else $error("write or read beat missing");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_run |=> busy_o || done_o)
    else $error("run neither started nor refused");

  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result beat while busy");

  a_value_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!done_o || status_o) |-> read_value_o == '0)
    else $error("read value outside a good read beat");

endmodule

bind inverse_2d_nonseparable_53_wavelet iw53_chk u_chk (
  .clk_i,
  .rst_ni,
  .start_i,
  .busy_o,
  .command_i,
  .done_o,
  .read_value_o,
  .status_o
);
`default_nettype wire

// ===== tb/tb_inverse_2d_nonseparable_53_wavelet.sv =====
`default_nettype none
module tb_inverse_2d_nonseparable_53_wavelet;

  localparam int WSTR = iw53_pkg::MAX_WIDTH_DEF + 2;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [iw53_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic [iw53_pkg::CMD_W-1:0]          cmd;
    logic [iw53_pkg::POS_W-1:0]          col;
    logic [iw53_pkg::POS_W-1:0]          row;
    logic signed [iw53_pkg::VALUE_W-1:0] wval;
    logic [iw53_pkg::DIM_W-1:0]          rw;
    logic [iw53_pkg::DIM_W-1:0]          rh;
    logic signed [iw53_pkg::VALUE_W-1:0] want_rd;
    logic                                want_st;
  } coef_cmd_t;

  logic clk_i, rst_ni, start_i, busy_o, done_o, status_o;
  logic [iw53_pkg::CMD_W-1:0] command_i;
  logic [iw53_pkg::POS_W-1:0] column_i, row_i;
  logic signed [iw53_pkg::VALUE_W-1:0] write_value_i, read_value_o;
  logic [iw53_pkg::DIM_W-1:0] region_width_i, region_height_i, cfg_data_i;
  logic cfg_we_i, cfg_index_i;

  inverse_2d_nonseparable_53_wavelet uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .command_i(command_i), .column_i(column_i), .row_i(row_i),
    .write_value_i(write_value_i), .region_width_i(region_width_i),
    .region_height_i(region_height_i), .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i), .done_o(done_o),
    .read_value_o(read_value_o), .status_o(status_o)
  );

  // shadow of the block's stores and registers
  logic signed [iw53_pkg::VALUE_W-1:0] img_mem [0:65535];
  bit                                  img_set [0:65535];
  logic signed [iw53_pkg::VALUE_W-1:0] lift_mem [0:WSTR*WSTR-1];
  int img_w, img_h;

  coef_cmd_t pend_q[$];
  coef_cmd_t result_q[$];
  coef_cmd_t held;
  int issued_n, checked_n, fails, gap, idle_cnt;
  bit calm;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fails++;
  endtask

  function automatic int lw(input int r, input int c);
    return int'(lift_mem[r*WSTR + c]);
  endfunction

  function automatic void lset(input int r, input int c, input int v);
    lift_mem[r*WSTR + c] = v[iw53_pkg::VALUE_W-1:0];
  endfunction

  function automatic void mirror_edges(input int w, input int h);
    for (int c = 1; c <= w; c++) begin
      lset(0, c, lw(2, c));
      lset(h+1, c, lw(h-1, c));
    end
    for (int r = 0; r <= h+1; r++) begin
      lset(r, 0, lw(r, 2));
      lset(r, w+1, lw(r, w-1));
    end
  endfunction

  function automatic int cross4(input int r, input int c);
    return lw(r-1, c) + lw(r+1, c) + lw(r, c-1) + lw(r, c+1);
  endfunction

  function automatic int diag4(input int r, input int c);
    return lw(r-1, c-1) + lw(r-1, c+1) + lw(r+1, c-1) + lw(r+1, c+1);
  endfunction

  function automatic void inverse_level(input int w, input int h);
    int hw, hh, cw, ch, t;
    hw = w/2; hh = h/2; cw = (w+1)/2; ch = (h+1)/2;
    for (int y = 0; y < hh; y++) begin
      for (int x = 0; x < hw; x++) lset(2*y+2, 2*x+2, int'(img_mem[y*img_w + x]));
      for (int x = 0; x < cw; x++) lset(2*y+2, 2*x+1, int'(img_mem[y*img_w + hw + x]));
    end
    for (int y = 0; y < ch; y++) begin
      for (int x = 0; x < cw; x++)
        lset(2*y+1, 2*x+1, int'(img_mem[(hh+y)*img_w + hw + x]));
      for (int x = 0; x < hw; x++) lset(2*y+1, 2*x+2, int'(img_mem[(hh+y)*img_w + x]));
    end
    mirror_edges(w, h);
    for (int r = 2; r <= h; r += 2)
      for (int c = 2; c <= w; c += 2) begin
        t = (cross4(r, c)*4 - diag4(r, c) + 8) >>> 4;
        lset(r, c, lw(r, c) - t);
      end
    mirror_edges(w, h);
    for (int r = 2; r <= h; r += 2)
      for (int c = 1; c <= w; c += 2) begin
        t = ((lw(r-1, c) + lw(r+1, c)) - 2*(lw(r, c-1) + lw(r, c+1)) + 2) >>> 2;
        lset(r, c, lw(r, c) - t);
      end
    mirror_edges(w, h);
    for (int r = 1; r <= h; r += 2)
      for (int c = 2; c <= w; c += 2) begin
        t = ((lw(r, c-1) + lw(r, c+1)) - 2*(lw(r-1, c) + lw(r+1, c)) + 2) >>> 2;
        lset(r, c, lw(r, c) - t);
      end
    mirror_edges(w, h);
    for (int r = 1; r <= h; r += 2)
      for (int c = 1; c <= w; c += 2) begin
        t = (cross4(r, c)*2 - diag4(r, c) + 2) >>> 2;
        lset(r, c, lw(r, c) + t);
      end
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) img_mem[y*img_w + x] = lift_mem[(y+1)*WSTR + x + 1];
  endfunction

  function automatic bit image_ok();
    return img_w <= iw53_pkg::MAX_WIDTH_DEF && img_h <= iw53_pkg::MAX_HEIGHT_DEF;
  endfunction

  // works out the answer and pushes the command
  task automatic issue(input coef_cmd_t it);
    bit pos_ok;
    pos_ok = image_ok() && it.col < img_w && it.row < img_h;
    it.want_rd = '0;
    it.want_st = 1'b0;
    case (it.cmd)
      iw53_pkg::CMD_WRITE: begin
        if (pos_ok) begin
          img_mem[it.row*img_w + it.col] = it.wval;
          img_set[it.row*img_w + it.col] = 1'b1;
        end else it.want_st = 1'b1;
      end
      iw53_pkg::CMD_READ: begin
        if (pos_ok) it.want_rd = img_mem[it.row*img_w + it.col];
        else it.want_st = 1'b1;
      end
      iw53_pkg::CMD_RUN: begin
        if (image_ok() && it.rw >= 2 && it.rh >= 2 && it.rw <= img_w && it.rh <= img_h)
          inverse_level(it.rw, it.rh);
        else it.want_st = 1'b1;
      end
      default: it.want_st = 1'b1;
    endcase
    pend_q.push_back(it);
    issued_n++;
  endtask

  function automatic coef_cmd_t noise_cmd(input logic [iw53_pkg::CMD_W-1:0] cmd);
    coef_cmd_t it;
    it.cmd = cmd;
    it.col = iw53_pkg::POS_W'($urandom);
    it.row = iw53_pkg::POS_W'($urandom);
    it.wval = iw53_pkg::VALUE_W'($urandom);
    it.rw = iw53_pkg::DIM_W'($urandom);
    it.rh = iw53_pkg::DIM_W'($urandom);
    return it;
  endfunction

  task automatic put_coef(input int x, input int y, input int v);
    coef_cmd_t it;
    it = noise_cmd(iw53_pkg::CMD_WRITE);
    it.col = iw53_pkg::POS_W'(x); it.row = iw53_pkg::POS_W'(y);
    it.wval = iw53_pkg::VALUE_W'(v);
    issue(it);
  endtask

  task automatic get_coef(input int x, input int y);
    coef_cmd_t it;
    it = noise_cmd(iw53_pkg::CMD_READ);
    it.col = iw53_pkg::POS_W'(x); it.row = iw53_pkg::POS_W'(y);
    issue(it);
  endtask

  task automatic run_region(input int w, input int h);
    coef_cmd_t it;
    // fill anything the run would gather that was never written
    if (image_ok() && w >= 2 && h >= 2 && w <= img_w && h <= img_h)
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++)
          if (!img_set[y*img_w + x]) put_coef(x, y, $urandom);
    it = noise_cmd(iw53_pkg::CMD_RUN);
    it.rw = iw53_pkg::DIM_W'(w); it.rh = iw53_pkg::DIM_W'(h);
    issue(it);
  endtask

  task automatic drain();
    while (checked_n < issued_n) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_image(input int w, input int h);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= iw53_pkg::CFG_IMG_WIDTH;
    cfg_data_i <= iw53_pkg::DIM_W'(w);
    @(posedge clk_i);
    cfg_index_i <= iw53_pkg::CFG_IMG_HEIGHT; cfg_data_i <= iw53_pkg::DIM_W'(h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    img_w = w; img_h = h;
  endtask

  task automatic random_mix(input int n);
    int sel, x, y, lim_w, lim_h;
    bit found;
    lim_w = (img_w < 256) ? img_w : 256;
    lim_h = (img_h < 256) ? img_h : 256;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      calm = (i % 80) < 20;
      if (!image_ok()) issue(noise_cmd(iw53_pkg::CMD_W'($urandom_range(0, 3))));
      else if (sel < 45) begin
        if ($urandom_range(0, 9) == 0 && img_w < 256) x = $urandom_range(img_w, 255);
        else x = $urandom_range(0, lim_w - 1);
        if ($urandom_range(0, 9) == 0 && img_h < 256) y = $urandom_range(img_h, 255);
        else y = $urandom_range(0, lim_h - 1);
        put_coef(x, y, $urandom);
      end else if (sel < 75) begin
        found = 1'b0;
        if ($urandom_range(0, 9) == 0 && img_w < 256) begin
          x = $urandom_range(img_w, 255); y = $urandom; found = 1'b1;
        end
        for (int k = 0; k < 12 && !found; k++) begin
          x = $urandom_range(0, lim_w - 1);
          y = $urandom_range(0, lim_h - 1);
          found = img_set[y*img_w + x];
        end
        if (found) get_coef(x, y);
        else put_coef(x, y, $urandom);
      end else if (sel < 88) begin
        x = $urandom_range(2, (lim_w < 12) ? lim_w : 12);
        y = $urandom_range(2, (lim_h < 12) ? lim_h : 12);
        run_region(x, y);
      end else if (sel < 94) issue(noise_cmd(CMD_UNKNOWN));
      else begin
        // region meant to be refused; a swapped draw can still fit a tall image
        if ($urandom_range(0, 1)) begin
          x = $urandom_range(0, 1); y = $urandom_range(0, 511);
        end else begin
          x = (img_w < 511) ? $urandom_range(img_w + 1, 511) : 0;
          y = $urandom_range(0, 511);
        end
        if ($urandom_range(0, 1)) run_region(x, y);
        else run_region(y, x);
      end
    end
    calm = 1'b0;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) result_q.push_back(held);
      if (!start_i || !busy_o) begin
        if (gap > 0) begin
          gap <= gap - 1;
          start_i <= 1'b0;
        end else if (pend_q.size() > 0) begin
          held = pend_q.pop_front();
          command_i <= held.cmd;
          column_i <= held.col;
          row_i <= held.row;
          write_value_i <= held.wval;
          region_width_i <= held.rw;
          region_height_i <= held.rh;
          start_i <= 1'b1;
          if (calm || $urandom_range(0, 9) < 6) gap <= 0;
          else if ($urandom_range(0, 9) < 8) gap <= $urandom_range(1, 3);
          else gap <= $urandom_range(5, 40);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    coef_cmd_t w;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        report("unexpected result beat", 0, 0);
      end else begin
        w = result_q.pop_front();
        if (read_value_o !== w.want_rd)
          report("read_value", int'(read_value_o), int'(w.want_rd));
        if (status_o !== w.want_st) report("status", int'(status_o), int'(w.want_st));
      end
      checked_n <= checked_n + 1;
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    command_i = '0; column_i = '0; row_i = '0; write_value_i = '0;
    region_width_i = '0; region_height_i = '0;
    cfg_we_i = 1'b0; cfg_index_i = 1'b0; cfg_data_i = '0;
    issued_n = 0; checked_n = 0; fails = 0; gap = 0; idle_cnt = 0; calm = 1'b0;
    img_w = 256; img_h = 256;
    for (int i = 0; i < 65536; i++) img_set[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner coefficients at the reset image size, odd commands, bad regions
    put_coef(0, 0, 20'sh7FFFF);
    put_coef(255, 255, -20'sh80000);
    get_coef(0, 0);
    get_coef(255, 255);
    issue(noise_cmd(CMD_UNKNOWN));
    run_region(1, 4);
    run_region(4, 257);
    run_region(0, 0);

    set_image(4, 4);
    for (int i = 0; i < 16; i++) put_coef(i % 4, i / 4, $urandom);
    put_coef(4, 0, 1);
    get_coef(0, 4);
    run_region(4, 4);
    get_coef(3, 3);
    run_region(5, 4);

    set_image(257, 4);
    put_coef(0, 0, 7);
    run_region(2, 2);
    drain();

    set_image(8, 8);     random_mix(40);
    set_image(2, 2);     random_mix(20);
    set_image(256, 256); random_mix(50);
    set_image(5, 7);     random_mix(35);
    set_image(300, 10);  random_mix(10);
    set_image(3, 256);   random_mix(30);
    set_image(256, 2);
    run_region(256, 2);
    random_mix(30);
    set_image(16, 12);   random_mix(40);
    set_image(511, 511); random_mix(10);
    set_image(2, 256);   random_mix(30);
    set_image(9, 3);     random_mix(35);

    drain();
    repeat (20) @(posedge clk_i);
    if (fails == 0 && result_q.size() == 0 && pend_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
